// ----- sv/i2cram_pkg.sv -----
// shared types and constants for the i2c register access master
// no dependencies
`default_nettype none

package i2cram_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_WAIT_LIMIT = 1'd1;

  localparam logic [6:0] RESET_DEVICE_ADDRESS = 7'd56;
  localparam logic [7:0] RESET_ACK_WAIT_LIMIT = 8'd101;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_HI  = 5'd1,
    PH_ST_SDA = 5'd2,
    PH_ST_SCL = 5'd3,
    PH_W_SET  = 5'd4,
    PH_W_HIGH = 5'd5,
    PH_W_FALL = 5'd6,
    PH_A_SET  = 5'd7,
    PH_A_WAIT = 5'd8,
    PH_A_FALL = 5'd9,
    PH_R_HIGH = 5'd10,
    PH_R_FALL = 5'd11,
    PH_M_SET  = 5'd12,
    PH_M_HIGH = 5'd13,
    PH_M_FALL = 5'd14,
    PH_P_LOW  = 5'd15,
    PH_P_SCL  = 5'd16,
    PH_P_SDA  = 5'd17
  } phase_t;

  typedef enum logic [1:0] {
    FR_ADDR_W = 2'd0,
    FR_REG    = 2'd1,
    FR_DATA   = 2'd2,
    FR_ADDR_R = 2'd3
  } frame_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef struct packed {
    logic       command_valid;
    logic       kind;
    logic [7:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic       status;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/i2cram_seq.sv -----
// bus phase sequencer: configuration registers, transaction state, pin levels
// depends on i2cram_pkg
`default_nettype none

module i2cram_seq (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [i2cram_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2cram_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                               step,
  input  wire i2cram_pkg::cmd_t                   cmd,
  output i2cram_pkg::res_t                        res
);

  logic [6:0] device_address;
  logic [7:0] ack_wait_limit;

  i2cram_pkg::phase_t phase, phase_next;
  i2cram_pkg::frame_t frame, frame_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] wait_count, wait_count_next;
  logic       nack_flag, nack_flag_next;
  logic       latched_kind, latched_kind_next;
  logic [7:0] latched_reg, latched_reg_next;
  logic [7:0] latched_data, latched_data_next;
  logic       restart_pending, restart_pending_next;

  i2cram_pkg::phase_t phase_eff;
  logic [3:0] bit_count_inc;
  logic [7:0] bytes_left_dec;
  logic       last_byte;

  function automatic logic [7:0] frame_byte(input i2cram_pkg::frame_t f,
                                            input logic [6:0] addr,
                                            input logic [7:0] rg,
                                            input logic [7:0] dat);
    logic [7:0] b;
    case (f)
      i2cram_pkg::FR_ADDR_W: b = {addr, 1'b0};
      i2cram_pkg::FR_REG:    b = rg;
      i2cram_pkg::FR_DATA:   b = dat;
      default:               b = {addr, 1'b1};
    endcase
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cram_pkg::RESET_DEVICE_ADDRESS;
      ack_wait_limit <= i2cram_pkg::RESET_ACK_WAIT_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        i2cram_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        i2cram_pkg::CFG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cram_pkg::PH_IDLE;
      frame           <= i2cram_pkg::FR_ADDR_W;
      bit_count       <= '0;
      shift_reg       <= '0;
      bytes_left      <= '0;
      wait_count      <= '0;
      nack_flag       <= 1'b0;
      latched_kind    <= 1'b0;
      latched_reg     <= '0;
      latched_data    <= '0;
      restart_pending <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      frame           <= frame_next;
      bit_count       <= bit_count_next;
      shift_reg       <= shift_reg_next;
      bytes_left      <= bytes_left_next;
      wait_count      <= wait_count_next;
      nack_flag       <= nack_flag_next;
      latched_kind    <= latched_kind_next;
      latched_reg     <= latched_reg_next;
      latched_data    <= latched_data_next;
      restart_pending <= restart_pending_next;
    end
  end

  assign bit_count_inc  = bit_count + 4'd1;
  assign bytes_left_dec = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;
  assign last_byte      = (bytes_left == 8'd1);

  // next state
  always_comb begin
    phase_next           = phase;
    frame_next           = frame;
    bit_count_next       = bit_count;
    shift_reg_next       = shift_reg;
    bytes_left_next      = bytes_left;
    wait_count_next      = wait_count;
    nack_flag_next       = nack_flag;
    latched_kind_next    = latched_kind;
    latched_reg_next     = latched_reg;
    latched_data_next    = latched_data;
    restart_pending_next = restart_pending;
    phase_eff            = phase;

    if (phase == i2cram_pkg::PH_IDLE && cmd.command_valid) begin
      latched_kind_next    = cmd.kind;
      latched_reg_next     = cmd.reg_index;
      latched_data_next    = cmd.write_data;
      bytes_left_next      = cmd.read_count;
      nack_flag_next       = 1'b0;
      wait_count_next      = '0;
      bit_count_next       = '0;
      shift_reg_next       = '0;
      frame_next           = i2cram_pkg::FR_ADDR_W;
      restart_pending_next = 1'b0;
      phase_eff            = i2cram_pkg::PH_ST_HI;
    end

    case (phase_eff)
      i2cram_pkg::PH_IDLE: ;
      i2cram_pkg::PH_ST_HI:  phase_next = i2cram_pkg::PH_ST_SDA;
      i2cram_pkg::PH_ST_SDA: phase_next = i2cram_pkg::PH_ST_SCL;
      i2cram_pkg::PH_ST_SCL: begin
        bit_count_next = '0;
        shift_reg_next = frame_byte(frame, device_address, latched_reg, latched_data);
        phase_next     = i2cram_pkg::PH_W_SET;
      end
      i2cram_pkg::PH_W_SET:  phase_next = i2cram_pkg::PH_W_HIGH;
      i2cram_pkg::PH_W_HIGH: phase_next = i2cram_pkg::PH_W_FALL;
      i2cram_pkg::PH_W_FALL: begin
        shift_reg_next = {shift_reg[6:0], 1'b0};
        bit_count_next = bit_count_inc;
        if (bit_count_inc >= i2cram_pkg::BITS_PER_BYTE) begin
          wait_count_next = '0;
          phase_next      = i2cram_pkg::PH_A_SET;
        end else begin
          phase_next = i2cram_pkg::PH_W_SET;
        end
      end
      i2cram_pkg::PH_A_SET: phase_next = i2cram_pkg::PH_A_WAIT;
      i2cram_pkg::PH_A_WAIT: begin
        if (!cmd.sda_sample) begin
          nack_flag_next = 1'b0;
          phase_next     = i2cram_pkg::PH_A_FALL;
        end else if (wait_count >= ack_wait_limit) begin
          nack_flag_next = 1'b1;
          phase_next     = i2cram_pkg::PH_A_FALL;
        end else begin
          wait_count_next = wait_count + 8'd1;
        end
      end
      i2cram_pkg::PH_A_FALL: begin
        case (frame)
          i2cram_pkg::FR_ADDR_W: begin
            if (nack_flag) begin
              phase_next = i2cram_pkg::PH_P_LOW;
            end else begin
              frame_next     = i2cram_pkg::FR_REG;
              bit_count_next = '0;
              shift_reg_next = latched_reg;
              phase_next     = i2cram_pkg::PH_W_SET;
            end
          end
          i2cram_pkg::FR_REG: begin
            if (latched_kind == i2cram_pkg::KIND_WRITE) begin
              frame_next     = i2cram_pkg::FR_DATA;
              bit_count_next = '0;
              shift_reg_next = latched_data;
              phase_next     = i2cram_pkg::PH_W_SET;
            end else begin
              if (!nack_flag) restart_pending_next = 1'b1;
              phase_next = i2cram_pkg::PH_P_LOW;
            end
          end
          i2cram_pkg::FR_DATA: phase_next = i2cram_pkg::PH_P_LOW;
          default: begin
            if (nack_flag || bytes_left == 8'd0) begin
              phase_next = i2cram_pkg::PH_P_LOW;
            end else begin
              bit_count_next = '0;
              shift_reg_next = '0;
              phase_next     = i2cram_pkg::PH_R_HIGH;
            end
          end
        endcase
      end
      i2cram_pkg::PH_R_HIGH: begin
        shift_reg_next = {shift_reg[6:0], cmd.sda_sample};
        phase_next     = i2cram_pkg::PH_R_FALL;
      end
      i2cram_pkg::PH_R_FALL: begin
        bit_count_next = bit_count_inc;
        if (bit_count_inc >= i2cram_pkg::BITS_PER_BYTE) begin
          phase_next = i2cram_pkg::PH_M_SET;
        end else begin
          phase_next = i2cram_pkg::PH_R_HIGH;
        end
      end
      i2cram_pkg::PH_M_SET:  phase_next = i2cram_pkg::PH_M_HIGH;
      i2cram_pkg::PH_M_HIGH: phase_next = i2cram_pkg::PH_M_FALL;
      i2cram_pkg::PH_M_FALL: begin
        bytes_left_next = bytes_left_dec;
        if (bytes_left_dec != 8'd0) begin
          bit_count_next = '0;
          shift_reg_next = '0;
          phase_next     = i2cram_pkg::PH_R_HIGH;
        end else begin
          phase_next = i2cram_pkg::PH_P_LOW;
        end
      end
      i2cram_pkg::PH_P_LOW: phase_next = i2cram_pkg::PH_P_SCL;
      i2cram_pkg::PH_P_SCL: phase_next = i2cram_pkg::PH_P_SDA;
      i2cram_pkg::PH_P_SDA: begin
        if (restart_pending) begin
          restart_pending_next = 1'b0;
          frame_next           = i2cram_pkg::FR_ADDR_R;
          phase_next           = i2cram_pkg::PH_ST_HI;
        end else begin
          phase_next = i2cram_pkg::PH_IDLE;
        end
      end
      default: phase_next = i2cram_pkg::PH_IDLE;
    endcase
  end

  // pin levels and result flags
  always_comb begin
    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.sda_drive  = 1'b1;
    res.busy_res   = (phase_eff != i2cram_pkg::PH_IDLE);

    case (phase_eff)
      i2cram_pkg::PH_IDLE, i2cram_pkg::PH_ST_HI: ;
      i2cram_pkg::PH_ST_SDA, i2cram_pkg::PH_P_SCL: res.sda_level = 1'b0;
      i2cram_pkg::PH_ST_SCL, i2cram_pkg::PH_P_LOW: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
      end
      i2cram_pkg::PH_W_SET, i2cram_pkg::PH_W_FALL: begin
        res.scl_level = 1'b0;
        res.sda_level = shift_reg[7];
      end
      i2cram_pkg::PH_W_HIGH: res.sda_level = shift_reg[7];
      i2cram_pkg::PH_A_SET, i2cram_pkg::PH_A_FALL: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
        res.sda_drive = 1'b0;
      end
      i2cram_pkg::PH_A_WAIT, i2cram_pkg::PH_R_HIGH: begin
        res.sda_level = 1'b0;
        res.sda_drive = 1'b0;
      end
      i2cram_pkg::PH_R_FALL: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
        res.sda_drive = 1'b0;
        if (bit_count_inc >= i2cram_pkg::BITS_PER_BYTE) begin
          res.byte_valid = 1'b1;
          res.read_byte  = shift_reg;
        end
      end
      i2cram_pkg::PH_M_SET, i2cram_pkg::PH_M_FALL: begin
        res.scl_level = 1'b0;
        res.sda_level = last_byte;
      end
      i2cram_pkg::PH_M_HIGH: res.sda_level = last_byte;
      i2cram_pkg::PH_P_SDA: begin
        if (!restart_pending) begin
          res.done_res = 1'b1;
          res.status   = nack_flag;
        end
      end
      default: res.busy_res = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/i2cram_out.sv -----
// result register between the sequencer and the output channel
// depends on i2cram_pkg
`default_nettype none

module i2cram_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire i2cram_pkg::res_t  res_in,
  output logic                   can_load,
  output logic                   valid,
  input  wire logic              ready,
  output i2cram_pkg::res_t       res_out
);

  logic             full;
  i2cram_pkg::res_t held;

  assign can_load = !full || ready;
  assign valid    = full;
  assign res_out  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/i2c_register_access_master_core.sv -----
// top level of the i2c register access master: sequencer and result register
// depends on i2cram_pkg, i2cram_seq, i2cram_out
`default_nettype none

// channel  direction  handshake            payload
// cfg      in         cfg_write            cfg_index, cfg_data
// in       in         in_valid / in_ready  command_valid .. sda_sample (one bus tick)
// out      out        out_valid / out_ready scl_level .. status (pin levels of that tick)
//
// one transfer in gives one transfer out; the sequencer advances one bus phase per
// accepted tick, so a transfer can be taken in every cycle while the output is not stalled
// a result is presented from the result register in the cycle after its tick is taken
// rst is synchronous: idle phase, sequencer lines high, result register empty, device_address 56, ack_wait_limit 101
// a stalled output holds the sequencer, since in_ready follows the result register:
// a new tick is taken only when the register is empty or its result leaves that cycle

module i2c_register_access_master_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [i2cram_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2cram_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               command_valid,
  input  wire logic                               kind,
  input  wire logic [7:0]                         reg_index,
  input  wire logic [7:0]                         write_data,
  input  wire logic [7:0]                         read_count,
  input  wire logic                               sda_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    scl_level,
  output logic                                    sda_level,
  output logic                                    sda_drive,
  output logic                                    busy_res,
  output logic                                    byte_valid,
  output logic [7:0]                              read_byte,
  output logic                                    done_res,
  output logic                                    status
);

  i2cram_pkg::cmd_t cmd;
  i2cram_pkg::res_t res_now;
  i2cram_pkg::res_t res_q;
  logic             step;

  assign cmd.command_valid = command_valid;
  assign cmd.kind          = kind;
  assign cmd.reg_index     = reg_index;
  assign cmd.write_data    = write_data;
  assign cmd.read_count    = read_count;
  assign cmd.sda_sample    = sda_sample;

  assign step = in_valid && in_ready;

  i2cram_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .cmd       (cmd),
    .res       (res_now)
  );

  i2cram_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res_in   (res_now),
    .can_load (in_ready),
    .valid    (out_valid),
    .ready    (out_ready),
    .res_out  (res_q)
  );

  assign scl_level  = res_q.scl_level;
  assign sda_level  = res_q.sda_level;
  assign sda_drive  = res_q.sda_drive;
  assign busy_res   = res_q.busy_res;
  assign byte_valid = res_q.byte_valid;
  assign read_byte  = res_q.read_byte;
  assign done_res   = res_q.done_res;
  assign status     = res_q.status;

endmodule

`default_nettype wire
